// ----- design/u8pd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package u8pd_pkg;

    // Field widths
    localparam int BYTE_BITS      = 8;
    localparam int CP_BITS        = 21;
    localparam int OFFSET_BITS    = 16;
    localparam int PARAGRAPH_BITS = 16;

    // Stream word widths (tdata padded to whole bytes)
    localparam int S_DATA_BITS = 8;
    localparam int M_FIELD_BITS = CP_BITS + OFFSET_BITS + PARAGRAPH_BITS;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RESULTS = 3;

    typedef logic [BYTE_BITS-1:0]      t_byte;
    typedef logic [CP_BITS-1:0]        t_cp;
    typedef logic [OFFSET_BITS-1:0]    t_offset;
    typedef logic [PARAGRAPH_BITS-1:0] t_para;

    // Command codes carried on tuser
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Sequence length codes
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // Control characters that are dropped
    localparam t_cp CP_TAB = t_cp'(8'h09);
    localparam t_cp CP_LF  = t_cp'(8'h0A);
    localparam t_cp CP_CR  = t_cp'(8'h0D);

    typedef struct packed {
        logic    last;
        t_para   para;
        t_offset offset;
        t_cp     cp;
    } t_result;

    // Length of the sequence a lead byte opens, LEN_NONE for a stray byte
    function automatic logic [2:0] lead_length(input t_byte b);
        logic [2:0] len;
        if (b < 8'h80)                    len = LEN_ONE;
        else if ((b & 8'hE0) == 8'hC0)    len = LEN_TWO;
        else if ((b & 8'hF0) == 8'hE0)    len = LEN_THREE;
        else if ((b & 8'hF8) == 8'hF0)    len = LEN_FOUR;
        else                              len = LEN_NONE;
        return len;
    endfunction

    function automatic logic is_dropped(input t_cp cp);
        return (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_CR);
    endfunction

    function automatic t_offset offset_inc(input t_offset a);
        return (a == '1) ? a : a + t_offset'(1);
    endfunction

    function automatic t_offset offset_inc2(input t_offset a);
        logic [OFFSET_BITS:0] s;
        s = {1'b0, a} + (OFFSET_BITS+1)'(2);
        return s[OFFSET_BITS] ? '1 : s[OFFSET_BITS-1:0];
    endfunction

    function automatic t_para para_inc(input t_para a);
        return (a == '1) ? a : a + t_para'(1);
    endfunction

endpackage

`default_nettype wire

// ----- design/utf8_paragraph_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A decoded character is written into the result queue as its last byte is accepted.
// Throughput: one byte per cycle; an end marker pushes up to three words that drain at
// one word per cycle while the master side is ready, and the slave side stalls while more
// than one word sits in the four-entry result queue.
// Reset (synchronous, active low) clears the sequence state, counters and queue.

module utf8_paragraph_decoder (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [u8pd_pkg::S_DATA_BITS-1:0]    i_s_tdata,  // [7:0] data_byte
    input  wire                                 i_s_tuser,  // [0] cmd
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [u8pd_pkg::M_DATA_BITS-1:0]    o_m_tdata,  // [20:0] codepoint,
                                                            // [36:21] byte_offset,
                                                            // [52:37] paragraph_number,
                                                            // [55:53] zero
    output logic                                o_m_tlast   // last_of_run
);
    import u8pd_pkg::*;

    // Sequence state
    t_byte      r_pend [MAX_RESULTS];
    t_byte      n_pend [MAX_RESULTS];
    logic [1:0] r_pcount, n_pcount;
    logic [2:0] r_exp, n_exp;
    t_offset    r_run, n_run;
    t_offset    r_lead, n_lead;
    t_para      r_para, n_para;

    // Result queue
    t_result              r_q [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wp, r_rp;
    logic [QCNT_BITS-1:0] r_count, n_count;

    logic    s_accept, m_accept;
    t_byte   in_byte;
    logic    in_cmd;
    logic [2:0] len;

    logic    cand   [MAX_RESULTS];
    t_cp     cand_cp [MAX_RESULTS];
    t_offset cand_off [MAX_RESULTS];
    logic    keep   [MAX_RESULTS];
    t_result entry  [MAX_RESULTS];
    logic [QPTR_BITS-1:0] pos [MAX_RESULTS];
    logic [1:0] push_cnt;

    assign s_accept = i_s_tvalid & o_s_tready;
    assign m_accept = o_m_tvalid & i_m_tready;
    assign in_byte  = i_s_tdata[BYTE_BITS-1:0];
    assign in_cmd   = i_s_tuser;
    assign len      = lead_length(in_byte);

    // Decode one word against the sequence state
    always_comb begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            cand[i]     = 1'b0;
            cand_cp[i]  = '0;
            cand_off[i] = '0;
            n_pend[i]   = r_pend[i];
        end
        n_pcount = r_pcount;
        n_exp    = r_exp;
        n_run    = r_run;
        n_lead   = r_lead;
        n_para   = r_para;

        if (in_cmd == CMD_END) begin
            // Flush a cut-short sequence: lead raw, the rest parsed again
            if (r_pcount != 2'd0) begin
                cand[0]     = 1'b1;
                cand_cp[0]  = t_cp'(r_pend[0]);
                cand_off[0] = r_lead;
                if (r_pcount == 2'd2) begin
                    cand[1]     = 1'b1;
                    cand_cp[1]  = t_cp'(r_pend[1]);
                    cand_off[1] = offset_inc(r_lead);
                end else if (r_pcount == 2'd3) begin
                    cand[1]     = 1'b1;
                    cand_off[1] = offset_inc(r_lead);
                    if (lead_length(r_pend[1]) == LEN_TWO) begin
                        cand_cp[1] = t_cp'({r_pend[1][4:0], r_pend[2][5:0]});
                    end else begin
                        cand_cp[1]  = t_cp'(r_pend[1]);
                        cand[2]     = 1'b1;
                        cand_cp[2]  = t_cp'(r_pend[2]);
                        cand_off[2] = offset_inc2(r_lead);
                    end
                end
            end
            n_pcount = 2'd0;
            n_exp    = LEN_NONE;
            n_run    = '0;
            n_para   = para_inc(r_para);
        end else if (r_pcount == 2'd0) begin
            // Expect a lead byte
            if (len == LEN_ONE || len == LEN_NONE) begin
                cand[0]     = 1'b1;
                cand_cp[0]  = t_cp'(in_byte);
                cand_off[0] = r_run;
            end else begin
                n_pend[0] = in_byte;
                n_pcount  = 2'd1;
                n_exp     = len;
                n_lead    = r_run;
            end
            n_run = offset_inc(r_run);
        end else begin
            // Continuation byte: complete or hold
            if (({1'b0, r_pcount} + 3'd1) >= r_exp) begin
                cand[0]     = 1'b1;
                cand_off[0] = r_lead;
                case (r_exp)
                    LEN_TWO:   cand_cp[0] = t_cp'({r_pend[0][4:0], in_byte[5:0]});
                    LEN_THREE: cand_cp[0] = t_cp'({r_pend[0][3:0], r_pend[1][5:0],
                                                   in_byte[5:0]});
                    default:   cand_cp[0] = t_cp'({r_pend[0][2:0], r_pend[1][5:0],
                                                   r_pend[2][5:0], in_byte[5:0]});
                endcase
                n_pcount = 2'd0;
                n_exp    = LEN_NONE;
            end else begin
                n_pend[r_pcount] = in_byte;
                n_pcount         = r_pcount + 2'd1;
            end
            n_run = offset_inc(r_run);
        end
    end

    // Drop controls, pack the survivors and mark the last one
    always_comb begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            keep[i] = cand[i] & ~is_dropped(cand_cp[i]);
        end
        pos[0] = '0;
        pos[1] = QPTR_BITS'(keep[0]);
        pos[2] = QPTR_BITS'(keep[0]) + QPTR_BITS'(keep[1]);
        push_cnt = 2'(keep[0]) + 2'(keep[1]) + 2'(keep[2]);
        entry[0] = '{last: keep[0] & ~keep[1] & ~keep[2], para: r_para,
                     offset: cand_off[0], cp: cand_cp[0]};
        entry[1] = '{last: keep[1] & ~keep[2], para: r_para,
                     offset: cand_off[1], cp: cand_cp[1]};
        entry[2] = '{last: keep[2], para: r_para,
                     offset: cand_off[2], cp: cand_cp[2]};
    end

    always_comb begin
        n_count = r_count - QCNT_BITS'(m_accept);
        if (s_accept) begin
            n_count = n_count + QCNT_BITS'(push_cnt);
        end
    end

    // Advance sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= 2'd0;
            r_exp    <= LEN_NONE;
            r_run    <= '0;
            r_lead   <= '0;
            r_para   <= '0;
        end else if (s_accept) begin
            r_pcount <= n_pcount;
            r_exp    <= n_exp;
            r_run    <= n_run;
            r_lead   <= n_lead;
            r_para   <= n_para;
        end
    end

    // Hold pending bytes
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                r_pend[i] <= n_pend[i];
            end
        end
    end

    // Write results into the queue
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                if (keep[i]) begin
                    r_q[r_wp + pos[i]] <= entry[i];
                end
            end
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (s_accept) begin
                r_wp <= r_wp + QPTR_BITS'(push_cnt);
            end
            if (m_accept) begin
                r_rp <= r_rp + QPTR_BITS'(1);
            end
        end
    end

    // Take a word only while room for a full flush remains
    assign o_s_tready = (r_count <= QCNT_BITS'(1));
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = M_DATA_BITS'({r_q[r_rp].para, r_q[r_rp].offset, r_q[r_rp].cp});
    assign o_m_tlast  = r_q[r_rp].last;

    // Checks
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_pending_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcount != 2'd0) |-> ({1'b0, r_pcount} < r_exp))
        else $error("pending count reached sequence length");

    a_idle_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcount == 2'd0) == (r_exp == LEN_NONE))
        else $error("pending count and sequence length disagree");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && in_cmd == CMD_END) |=> (r_pcount == 2'd0 && r_run == '0))
        else $error("end marker left sequence state");

endmodule

`default_nettype wire

// ----- dv/utf8_decode_scoreboard.sv -----
`timescale 1ns / 1ps

module utf8_decode_scoreboard (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    input  wire                                 i_s_tready,
    input  wire  [u8pd_pkg::S_DATA_BITS-1:0]    i_s_tdata,  // [7:0] data_byte
    input  wire                                 i_s_tuser,  // [0] cmd
    input  wire                                 i_m_tvalid,
    input  wire                                 i_m_tready,
    input  wire  [u8pd_pkg::M_DATA_BITS-1:0]    i_m_tdata,  // [20:0] codepoint,
                                                            // [36:21] byte_offset,
                                                            // [52:37] paragraph_number,
                                                            // [55:53] zero
    input  wire                                 i_m_tlast,  // last_of_run
    output int                                  o_fail_count,
    output int                                  o_outstanding
);
    import u8pd_pkg::*;

    // Decoder state as the scoreboard tracks it
    t_byte      held[3];
    logic [1:0] held_cnt;
    logic [2:0] seq_len;
    t_offset    next_off;
    t_offset    lead_pos;
    t_para      para_idx;

    // Characters still owed by the block, oldest first
    t_result    owed_chars[$];
    int         burst_n;
    int         mismatches;

    initial begin
        mismatches = 0;
    end

    function automatic logic [2:0] seq_length(input t_byte b);
        logic [2:0] len;
        casez (b)
            8'b0???????: len = LEN_ONE;
            8'b110?????: len = LEN_TWO;
            8'b1110????: len = LEN_THREE;
            8'b11110???: len = LEN_FOUR;
            default:     len = LEN_NONE;
        endcase
        return len;
    endfunction

    // Saturating offset add
    function automatic t_offset off_plus(input t_offset a, input int k);
        longint s;
        s = longint'(a) + longint'(k);
        return (s > longint'({OFFSET_BITS{1'b1}})) ? {OFFSET_BITS{1'b1}} : t_offset'(s);
    endfunction

    // Queue one character unless it is a dropped control or the word already queued MAX_RESULTS
    task automatic owe_char(input t_cp cp, input t_offset off);
        t_result r;
        if (cp == CP_TAB || cp == CP_LF || cp == CP_CR || burst_n >= MAX_RESULTS) begin
            return;
        end
        r.cp     = cp;
        r.offset = off;
        r.para   = para_idx;
        r.last   = 1'b0;
        owed_chars.insert(owed_chars.size(), r);
        burst_n++;
    endtask

    // Advance the decoder by one accepted input word
    task automatic decode_word(input logic cmd, input t_byte b);
        int      i;
        t_byte   c;
        t_cp     cp;
        burst_n = 0;
        if (cmd == CMD_END) begin
            // flush a cut-short sequence: lead raw, the rest parsed again as leads
            if (held_cnt != 2'd0) begin
                owe_char(t_cp'(held[0]), lead_pos);
                i = 1;
                while (i < int'(held_cnt)) begin
                    c = held[i];
                    if (seq_length(c) == LEN_TWO && i + 1 < int'(held_cnt)) begin
                        cp = t_cp'({c[4:0], held[i+1][5:0]});
                        owe_char(cp, off_plus(lead_pos, i));
                        i += 2;
                    end else begin
                        owe_char(t_cp'(c), off_plus(lead_pos, i));
                        i += 1;
                    end
                end
            end
            held_cnt = 2'd0;
            seq_len  = LEN_NONE;
            next_off = '0;
            para_idx = (para_idx == {PARAGRAPH_BITS{1'b1}}) ? para_idx : para_idx + 1'b1;
        end else if (held_cnt == 2'd0) begin
            // expecting a lead byte
            if (seq_length(b) == LEN_ONE || seq_length(b) == LEN_NONE) begin
                owe_char(t_cp'(b), next_off);
            end else begin
                held[0]  = b;
                held_cnt = 2'd1;
                seq_len  = seq_length(b);
                lead_pos = next_off;
            end
            next_off = off_plus(next_off, 1);
        end else begin
            // continuation: taken unchecked, low six bits only
            if (int'(held_cnt) + 1 >= int'(seq_len)) begin
                case (seq_len)
                    LEN_TWO:   cp = t_cp'({held[0][4:0], b[5:0]});
                    LEN_THREE: cp = t_cp'({held[0][3:0], held[1][5:0], b[5:0]});
                    default:   cp = t_cp'({held[0][2:0], held[1][5:0], held[2][5:0],
                                           b[5:0]});
                endcase
                owe_char(cp, lead_pos);
                held_cnt = 2'd0;
                seq_len  = LEN_NONE;
            end else begin
                held[held_cnt] = b;
                held_cnt       = held_cnt + 2'd1;
            end
            next_off = off_plus(next_off, 1);
        end
        if (burst_n > 0) begin
            owed_chars[owed_chars.size()-1].last = 1'b1;
        end
    endtask

    // Watch both channels: predict on input words, compare on output words
    always @(posedge i_clk) begin : track
        t_result want;
        t_cp     got_cp;
        t_offset got_off;
        t_para   got_para;
        logic [M_DATA_BITS-1:M_FIELD_BITS] got_pad;
        if (!i_rst_n) begin
            held_cnt = 2'd0;
            seq_len  = LEN_NONE;
            next_off = '0;
            lead_pos = '0;
            para_idx = '0;
            owed_chars.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                decode_word(i_s_tuser, i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                got_cp   = i_m_tdata[CP_BITS-1:0];
                got_off  = i_m_tdata[CP_BITS +: OFFSET_BITS];
                got_para = i_m_tdata[CP_BITS+OFFSET_BITS +: PARAGRAPH_BITS];
                got_pad  = i_m_tdata[M_DATA_BITS-1:M_FIELD_BITS];
                if (owed_chars.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected word cp=%h off=%0d para=%0d last=%b",
                                 $realtime, got_cp, got_off, got_para, i_m_tlast);
                    end
                    mismatches++;
                end else begin
                    want = owed_chars.pop_front();
                    if (got_cp !== want.cp || got_off !== want.offset ||
                        got_para !== want.para || i_m_tlast !== want.last ||
                        got_pad !== '0) begin
                        if (mismatches < 10) begin
                            $display("%0t: expected cp=%h off=%0d para=%0d last=%b",
                                     $realtime, want.cp, want.offset, want.para, want.last);
                            $display("%0t:      got cp=%h off=%0d para=%0d last=%b pad=%h",
                                     $realtime, got_cp, got_off, got_para, i_m_tlast,
                                     got_pad);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_outstanding <= owed_chars.size();
        o_fail_count  <= mismatches;
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import u8pd_pkg::*;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata  = '0;
    logic                   s_tuser  = CMD_DATA;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;
    logic                   m_tlast;

    int fail_count;
    int outstanding;
    int words_sent = 0;
    bit send_gaps  = 1'b1;
    bit take_gaps  = 1'b1;
    bit hold_req   = 1'b0;

    always #6 clk = ~clk;

    utf8_paragraph_decoder uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    utf8_decode_scoreboard sb (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tlast     (m_tlast),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Offer one word, after an optional gap; valid stays high when no gap follows
    task automatic put_word(input logic cmd, input t_byte b);
        int gap;
        gap = send_gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        words_sent++;
    endtask

    task automatic put_byte(input t_byte b);
        put_word(CMD_DATA, b);
    endtask

    // End marker; its data byte is ignored, so fill it with noise
    task automatic put_end();
        put_word(CMD_END, t_byte'($urandom));
    endtask

    // Drop valid and hold until every owed character has come out
    task automatic drain_chars();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic t_byte lead_for(input int len);
        t_byte b;
        case (len)
            2:       b = {3'b110, 5'($urandom)};
            3:       b = {4'b1110, 4'($urandom)};
            default: b = {5'b11110, 3'($urandom)};
        endcase
        return b;
    endfunction

    // Mostly proper continuation bytes, now and then anything at all
    function automatic t_byte tail_byte();
        t_byte b;
        if ($urandom_range(0, 7) == 0) b = t_byte'($urandom);
        else                           b = {2'b10, 6'($urandom)};
        return b;
    endfunction

    // One piece of random text: mostly well-formed characters, some noise
    task automatic put_text_piece();
        int kind;
        int len;
        int cut;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            put_byte(t_byte'($urandom_range(0, 127)));
        end else if (kind < 80) begin
            len = (kind < 55) ? 2 : (kind < 70) ? 3 : 4;
            put_byte(lead_for(len));
            repeat (len - 1) put_byte(tail_byte());
        end else if (kind < 86) begin
            // stray byte where a lead belongs
            if ($urandom_range(0, 1) == 1) put_byte(t_byte'($urandom_range(8'h80, 8'hBF)));
            else                           put_byte(t_byte'($urandom_range(8'hF8, 8'hFF)));
        end else if (kind < 92) begin
            // sequence cut short by the end marker
            len = $urandom_range(2, 4);
            cut = $urandom_range(0, len - 2);
            put_byte(lead_for(len));
            repeat (cut) begin
                case ($urandom_range(0, 3))
                    0:       put_byte(lead_for(2));
                    1:       put_byte(t_byte'($urandom_range(0, 127)));
                    default: put_byte(t_byte'($urandom));
                endcase
            end
            put_end();
        end else if (kind < 96) begin
            put_end();
        end else begin
            put_byte(t_byte'($urandom));
        end
    endtask

    // Receiver: random stalls per word, one long hold-off on request
    initial begin : take_chars
        int stall;
        wait (rst_n);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            stall = take_gaps ? $urandom_range(0, 17) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin : drive_text
        int  rand_end;
        int  next_mix;
        bit  held_off;
        bit  paused;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // ASCII extremes and dropped controls
        put_byte(8'h00);
        put_byte(8'h7F);
        put_byte(8'h09);
        put_byte(8'h0A);
        put_byte(8'h0D);
        // two-, three- and four-byte characters
        put_byte(8'hC3); put_byte(8'hA9);
        put_byte(8'hE2); put_byte(8'h82); put_byte(8'hAC);
        put_byte(8'hF0); put_byte(8'h9F); put_byte(8'h98); put_byte(8'h80);
        // stray bytes
        put_byte(8'h80);
        put_byte(8'hFF);
        // overlong newline is still dropped
        put_byte(8'hC0); put_byte(8'h8A);
        // flush: lead raw, then a two-byte lead decoded from the pending bytes
        put_byte(8'hF0); put_byte(8'hC3); put_byte(8'hA9);
        put_end();
        // flush: lead raw, then an ASCII byte
        put_byte(8'hE2); put_byte(8'h41);
        put_end();
        // empty paragraph
        put_end();
        drain_chars();

        // random text with mixed idling, one long hold-off and one full pause
        rand_end = words_sent + 180;
        next_mix = words_sent + 40;
        held_off = 1'b0;
        paused   = 1'b0;
        while (words_sent < rand_end) begin
            if (words_sent >= next_mix) begin
                send_gaps = ($urandom_range(0, 3) != 0);
                take_gaps = ($urandom_range(0, 3) != 0);
                next_mix  = words_sent + 40;
            end
            if (!held_off && words_sent >= rand_end - 140) begin
                hold_req = 1'b1;
                held_off = 1'b1;
            end
            if (!paused && words_sent >= rand_end - 70) begin
                drain_chars();
                paused = 1'b1;
            end
            put_text_piece();
        end
        drain_chars();

        send_gaps = 1'b1;
        take_gaps = 1'b1;
        repeat (20) put_text_piece();

        // wait out the tail of the stream
        drain_chars();
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial begin : watchdog
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
